### design/positional_list_store_unit_macros.svh
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define PLS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define PLS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pls_pkg.sv
`default_nettype none

package pls_pkg;

    // Field widths of the command and response beats.
    localparam int unsigned MODE_W = 2;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned LEN_W  = 5;

    // Default number of entries the store holds.
    localparam int unsigned DEF_CAPACITY = 16;

    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ST_W-1:0]          t_status;
    typedef logic [LEN_W-1:0]         t_len;

    // Operation codes.
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_DELETE = 2'd1;
    localparam t_mode MODE_READ   = 2'd2;

    // Status codes.
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RWAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### design/pls_if.sv
`default_nettype none

// Command channel: one operation per beat.
interface pls_cmd_if;
    import pls_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode;
    t_pos  position;
    t_data value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// Response channel: one result per command.
interface pls_rsp_if;
    import pls_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_data   read_value;
    t_len    length;

    modport source (output valid, output status, output read_value, output length, input ready);
    modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

`default_nettype wire

### design/pls_ram.sv
`default_nettype none

module pls_ram #(
    parameter int unsigned DEPTH = pls_pkg::DEF_CAPACITY,
    parameter int unsigned DW    = pls_pkg::DATA_W,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/positional_list_store_unit.sv
// Channel | Role | Beat contents
// --------+------+------------------------------------------
// i_cmd   | sink | mode, position, value
// o_rsp   | src  | status, read_value, length
//
// One command is taken at a time; i_cmd.ready is high only while the sequencer is idle.
// Insert runs S_EVAL, S_PUT, S_DONE at the end of the list, else S_EVAL, S_SHIFT,
// S_DRAIN, S_PUT, S_DONE; delete runs S_EVAL, S_DONE for the last entry, else S_EVAL,
// S_SHIFT, S_DRAIN, S_DONE; read S_EVAL, S_RWAIT, S_DONE; a rejected one S_EVAL, S_DONE.
// The walk moves one entry per cycle through the single write and registered read port.
// Reset is synchronous and clears the entry count; entry contents are not cleared.
// A finished result waits in the response register; a new command may be taken meanwhile.
`default_nettype none
`include "positional_list_store_unit_macros.svh"

module positional_list_store_unit #(
    parameter int unsigned CAPACITY = pls_pkg::DEF_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pls_cmd_if.sink   i_cmd,
    pls_rsp_if.source o_rsp
);
    import pls_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = (OW > POS_W) ? OW : POS_W;

    t_state r_state, n_state;

    // Latched command.
    t_mode r_mode, n_mode;
    t_pos  r_pos,  n_pos;
    t_data r_val,  n_val;

    // Store bookkeeping and walk pointers.
    logic [OW-1:0] r_occ, n_occ;
    logic [AW-1:0] r_hole, n_hole;
    logic [AW-1:0] r_limit, n_limit;
    logic [AW-1:0] r_wr, n_wr;
    logic          r_pend, n_pend;

    // Result being built and the response register.
    t_status r_st, n_st;
    t_data   r_rd, n_rd;
    logic    r_out_valid, n_out_valid;
    t_status r_out_st, n_out_st;
    t_data   r_out_rd, n_out_rd;
    t_len    r_out_len, n_out_len;

    // RAM port.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [CW-1:0] pos_x, occ_x, occ_m1;
    logic          full, empty, out_free;
    logic [AW-1:0] src;
    t_status       ev_st;

    pls_ram #(
        .DEPTH (CAPACITY),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Range checks on the latched command.
    assign pos_x    = CW'(r_pos);
    assign occ_x    = CW'(r_occ);
    assign occ_m1   = occ_x - CW'(1);
    assign full     = (r_occ == OW'(CAPACITY));
    assign empty    = (r_occ == '0);
    assign out_free = !r_out_valid || o_rsp.ready;

    // Shared step unit: one below the hole for insert, one above for delete.
    assign src = r_hole + ((r_mode == MODE_DELETE) ? AW'(1) : {AW{1'b1}});

    // Status decision for the latched command.
    always_comb begin
        ev_st = ST_DONE;
        unique case (r_mode) inside
            MODE_INSERT: begin
                if (full) begin
                    ev_st = ST_FULL;
                end else if (pos_x > occ_x) begin
                    ev_st = ST_RANGE;
                end
            end
            MODE_DELETE, MODE_READ: begin
                if (empty) begin
                    ev_st = ST_EMPTY;
                end else if (pos_x >= occ_x) begin
                    ev_st = ST_RANGE;
                end
            end
            default: begin
                ev_st = ST_RANGE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (ev_st != ST_DONE) begin
                    n_state = S_DONE;
                end else if (r_mode == MODE_INSERT) begin
                    n_state = (pos_x == occ_x) ? S_PUT : S_SHIFT;
                end else if (r_mode == MODE_DELETE) begin
                    n_state = (pos_x == occ_m1) ? S_DONE : S_SHIFT;
                end else begin
                    n_state = S_RWAIT;
                end
            end
            S_SHIFT: begin
                if (src == r_limit) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_mode == MODE_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_RWAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and response register loads.
    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_val       = r_val;
        n_occ       = r_occ;
        n_hole      = r_hole;
        n_limit     = r_limit;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_st        = r_st;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_st    = r_out_st;
        n_out_rd    = r_out_rd;
        n_out_len   = r_out_len;
        ram_we      = 1'b0;
        ram_waddr   = r_wr;
        ram_wdata   = ram_rdata;
        ram_raddr   = src;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_mode = i_cmd.mode;
                    n_pos  = i_cmd.position;
                    n_val  = i_cmd.value;
                end
            end
            S_EVAL: begin
                n_st   = ev_st;
                n_rd   = '0;
                n_pend = 1'b0;
                if (r_mode == MODE_INSERT) begin
                    n_hole  = occ_x[AW-1:0];
                    n_limit = pos_x[AW-1:0];
                end else begin
                    n_hole  = pos_x[AW-1:0];
                    n_limit = occ_m1[AW-1:0];
                end
                // Read the entry for a read command.
                ram_raddr = pos_x[AW-1:0];
                // Deleting the last entry needs no walk.
                if ((ev_st == ST_DONE) && (r_mode == MODE_DELETE) && (pos_x == occ_m1)) begin
                    n_occ = r_occ - OW'(1);
                end
            end
            S_SHIFT: begin
                // Read the next source and write the one fetched last cycle.
                n_pend = 1'b1;
                n_wr   = r_hole;
                n_hole = src;
                ram_we = r_pend;
            end
            S_DRAIN: begin
                ram_we = 1'b1;
                if (r_mode == MODE_DELETE) begin
                    n_occ = r_occ - OW'(1);
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_hole;
                ram_wdata = r_val;
                n_occ     = r_occ + OW'(1);
            end
            S_RWAIT: begin
                n_rd = ram_rdata;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_out_rd    = r_rd;
                    n_out_len   = occ_x[LEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_hole    <= n_hole;
        r_limit   <= n_limit;
        r_wr      <= n_wr;
        r_st      <= n_st;
        r_rd      <= n_rd;
        r_out_st  <= n_out_st;
        r_out_rd  <= n_out_rd;
        r_out_len <= n_out_len;
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.length     = r_out_len;

    // Checks on the sequencer and the store.
    `PLS_CHECK_NOW(a_occ_bound, 1'b1, r_occ <= OW'(CAPACITY), "entry count above capacity")
    `PLS_CHECK_NEXT(a_shift_keeps_occ, r_state == S_SHIFT, r_occ == $past(r_occ), "count moved during walk")
    `PLS_CHECK_NOW(a_full_status, (r_state == S_DONE) && (r_st == ST_FULL), full, "full status with room left")
    `PLS_CHECK_NOW(a_read_zero, o_rsp.valid && (o_rsp.status != ST_DONE), o_rsp.read_value == '0, "failed command returned data")

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import pls_pkg::*;

    localparam int unsigned DEPTH      = DEF_CAPACITY;
    localparam int          QUIET_MAX  = 2000;
    localparam int          PHASE_OPS  = 213;
    localparam int          NROWS      = 22;
    localparam t_mode       MODE_SPARE = 2'd3;

    // Fields of one response beat.
    typedef struct packed {
        t_status status;
        t_data   read_value;
        t_len    length;
    } t_result;

    // One line of the directed table; pinned rows carry their own expected beat.
    typedef struct {
        t_mode   mode;
        t_pos    pos;
        t_data   value;
        int      reps;
        bit      pinned;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    pls_cmd_if cmd_bus ();
    pls_rsp_if rsp_bus ();

    positional_list_store_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the list and the results still owed by the block.
    t_data   shadow_list [DEPTH];
    int      shadow_count = 0;
    t_result awaited_results [$];

    // Expected beat riding along with a directed command beat.
    bit      row_pinned;
    t_result row_want;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    int error_count  = 0;
    int cmd_count    = 0;
    int rsp_count    = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    // Directed rows: empty store, unused mode, extremes, full store, last-entry delete.
    t_row dir_rows [NROWS] = '{
        '{MODE_READ,   5'd0,  32'sd0,        1,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{MODE_DELETE, 5'd0,  32'sd0,        1,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{MODE_SPARE,  5'd31, -32'sd1,       1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0}},
        '{MODE_INSERT, 5'd1,  32'sd5,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0}},
        '{MODE_INSERT, 5'd0,  32'h7FFF_FFFF, 1,  1'b1, '{ST_DONE,  32'sd0, 5'd1}},
        '{MODE_DELETE, 5'd0,  32'sd0,        1,  1'b1, '{ST_DONE,  32'sd0, 5'd0}},
        '{MODE_INSERT, 5'd0,  32'h7FFF_FFFF, 1,  1'b1, '{ST_DONE,  32'sd0, 5'd1}},
        '{MODE_INSERT, 5'd0,  32'h8000_0000, 1,  1'b1, '{ST_DONE,  32'sd0, 5'd2}},
        '{MODE_READ,   5'd0,  32'sd0,        1,  1'b1, '{ST_DONE,  32'h8000_0000, 5'd2}},
        '{MODE_READ,   5'd1,  32'sd0,        1,  1'b1, '{ST_DONE,  32'h7FFF_FFFF, 5'd2}},
        '{MODE_READ,   5'd2,  32'sd0,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd2}},
        '{MODE_DELETE, 5'd2,  32'sd0,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd2}},
        '{MODE_INSERT, 5'd31, 32'sd9,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd2}},
        '{MODE_INSERT, 5'd2,  32'sd0,        1,  1'b0, '0},
        '{MODE_INSERT, 5'd1,  32'sd1234,     13, 1'b0, '0},
        '{MODE_INSERT, 5'd0,  32'sd77,       1,  1'b1, '{ST_FULL,  32'sd0, 5'd16}},
        '{MODE_INSERT, 5'd31, 32'sd77,       1,  1'b1, '{ST_FULL,  32'sd0, 5'd16}},
        '{MODE_READ,   5'd15, 32'sd0,        1,  1'b0, '0},
        '{MODE_READ,   5'd16, 32'sd0,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd16}},
        '{MODE_DELETE, 5'd15, 32'sd0,        1,  1'b1, '{ST_DONE,  32'sd0, 5'd15}},
        '{MODE_DELETE, 5'd31, 32'sd0,        1,  1'b1, '{ST_RANGE, 32'sd0, 5'd15}},
        '{MODE_READ,   5'd7,  32'sd0,        1,  1'b0, '0}
    };

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow list and returns the beat it yields.
    function automatic t_result predict_list_op(t_mode m, t_pos p, t_data v);
        t_result r;
        int      k;
        r.status     = ST_DONE;
        r.read_value = '0;
        case (m)
            MODE_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p > shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = shadow_count; k > p; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[p] = v;
                    shadow_count++;
                end
            end
            MODE_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = p; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
                    shadow_count--;
                end
            end
            MODE_READ: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else if (p >= shadow_count) r.status = ST_RANGE;
                else r.read_value = shadow_list[p];
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.length = t_len'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Response side: the ready line stalls at the rate of the current phase.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Checks each response beat, then predicts each command beat taken at this edge.
    always @(posedge i_clk) begin
        t_result owed;
        t_result calc;
        bit      rsp_fire;
        bit      cmd_fire;
        rsp_fire = rsp_bus.valid && rsp_bus.ready;
        cmd_fire = cmd_bus.valid && cmd_bus.ready;
        if (i_rst_n) begin
            if (rsp_fire) begin
                rsp_count++;
                status_hits[rsp_bus.status]++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unrequested result status", rsp_bus.status, '0);
                end else begin
                    owed = awaited_results.pop_front();
                    if (rsp_bus.status !== owed.status)
                        report_mismatch("status", rsp_bus.status, owed.status);
                    if (rsp_bus.read_value !== owed.read_value)
                        report_mismatch("read_value", rsp_bus.read_value, owed.read_value);
                    if (rsp_bus.length !== owed.length)
                        report_mismatch("length", rsp_bus.length, owed.length);
                end
            end
            if (cmd_fire) begin
                cmd_count++;
                calc = predict_list_op(cmd_bus.mode, cmd_bus.position, cmd_bus.value);
                awaited_results.push_back(row_pinned ? row_want : calc);
            end
            quiet_cycles = (rsp_fire || cmd_fire) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: too long without any beat on either channel.
    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("%0t ns: no beat for %0d cycles", $time, QUIET_MAX);
        $display("positional_list_store_unit test failed");
        $finish;
    end

    // Sends one command beat, idling first at the sender rate, and waits for acceptance.
    task automatic drive_op(t_mode m, t_pos p, t_data v, bit pin, t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.mode     <= m;
        cmd_bus.position <= p;
        cmd_bus.value    <= v;
        row_pinned       <= pin;
        row_want         <= want;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    initial begin
        int    r;
        int    k;
        int    ph;
        int    n;
        int    plan_len;
        int    target;
        int    pick;
        t_mode m;
        t_pos  p;
        t_data v;

        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.mode     <= MODE_INSERT;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        row_pinned       <= 1'b0;
        row_want         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling on either side.
        for (r = 0; r < NROWS; r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                drive_op(dir_rows[r].mode, dir_rows[r].pos, t_data'(dir_rows[r].value + k),
                         dir_rows[r].pinned, dir_rows[r].want);
            end
        end

        // Random phases; each starts from a drained block so the length is known.
        target = 8;
        for (ph = 0; ph < 4; ph++) begin
            drain_results();
            tx_idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 38 : 0;
            rx_stall_pct = (ph == 2) ? 79 : (ph == 3) ? 38 : 0;
            plan_len     = shadow_count;
            for (n = 0; n < PHASE_OPS; n++) begin
                // Move the fill target now and then, often to the empty or full ends.
                if ($urandom_range(19) == 0) begin
                    pick   = $urandom_range(99);
                    target = (pick < 25) ? DEPTH : (pick < 40) ? 0 : $urandom_range(DEPTH, 0);
                end
                pick = $urandom_range(99);
                if (plan_len < target)
                    m = (pick < 60) ? MODE_INSERT : (pick < 85) ? MODE_READ : MODE_DELETE;
                else if (plan_len > target)
                    m = (pick < 60) ? MODE_DELETE : (pick < 85) ? MODE_READ : MODE_INSERT;
                else
                    m = (pick < 40) ? MODE_READ : (pick < 70) ? MODE_INSERT : MODE_DELETE;
                if (m == MODE_INSERT) p = t_pos'($urandom_range(plan_len, 0));
                else if (plan_len == 0) p = '0;
                else p = t_pos'($urandom_range(plan_len - 1, 0));
                // A slice of noise: any mode, any position.
                if ($urandom_range(99) < 10) begin
                    m = t_mode'($urandom_range(3));
                    p = t_pos'($urandom_range(31));
                end
                case ($urandom_range(9))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    3:       v = -32'sd1;
                    default: v = t_data'($urandom());
                endcase
                // Track the length the block will reach, for shaping only.
                if (m == MODE_INSERT && plan_len < DEPTH && p <= plan_len) plan_len++;
                else if (m == MODE_DELETE && plan_len > 0 && p < plan_len) plan_len--;
                drive_op(m, p, v, 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never returned", awaited_results.size(), '0);

        $display("Ran %0d commands and checked %0d results: done %0d, range %0d, full %0d, empty %0d",
                 cmd_count, rsp_count, status_hits[ST_DONE], status_hits[ST_RANGE],
                 status_hits[ST_FULL], status_hits[ST_EMPTY]);
        $display("Idle mixes: none, sender 79 pct, receiver 79 pct, both 38 pct");
        if (error_count == 0) begin
            $display("positional_list_store_unit test passed");
        end else begin
            $display("positional_list_store_unit test failed");
        end
        $finish;
    end

endmodule
